### sv/psdq_pkg.sv
// Package for the pillar signed distance query block.
// Holds widths, register indexes, sequencer op codes and the command,
// status, configuration and table entry structs used across the design. No dependencies.
`default_nettype none

package psdq_pkg;

  localparam int MAX_PILLARS = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  localparam int SQ_IN_W = 54;
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int DIV_NW = 42;
  localparam int DIV_DW = 28;

  localparam int IN_W = 144;
  localparam int OUT_W = 72;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_PILLAR_COUNT = 3'd0;
  localparam logic [2:0] REG_MAP_MIN_X = 3'd1;
  localparam logic [2:0] REG_MAP_MIN_Y = 3'd2;
  localparam logic [2:0] REG_MAP_MIN_Z = 3'd3;
  localparam logic [2:0] REG_MAP_MAX_X = 3'd4;
  localparam logic [2:0] REG_MAP_MAX_Y = 3'd5;
  localparam logic [2:0] REG_MAP_MAX_Z = 3'd6;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // datapath op codes
  localparam logic [4:0] OP_NONE = 5'd0;
  localparam logic [4:0] OP_CAPTURE = 5'd1;
  localparam logic [4:0] OP_LOAD = 5'd2;
  localparam logic [4:0] OP_READ = 5'd3;
  localparam logic [4:0] OP_DIFF = 5'd4;
  localparam logic [4:0] OP_SQR = 5'd5;
  localparam logic [4:0] OP_SUM = 5'd6;
  localparam logic [4:0] OP_RQ_START = 5'd7;
  localparam logic [4:0] OP_RQ_TAKE = 5'd8;
  localparam logic [4:0] OP_UX_START = 5'd9;
  localparam logic [4:0] OP_UX_TAKE = 5'd10;
  localparam logic [4:0] OP_UY_START = 5'd11;
  localparam logic [4:0] OP_UY_TAKE = 5'd12;
  localparam logic [4:0] OP_EXCESS = 5'd13;
  localparam logic [4:0] OP_EXSQ = 5'd14;
  localparam logic [4:0] OP_DQ_START = 5'd15;
  localparam logic [4:0] OP_DQ_TAKE = 5'd16;
  localparam logic [4:0] OP_GX_MUL = 5'd17;
  localparam logic [4:0] OP_GX_START = 5'd18;
  localparam logic [4:0] OP_GX_TAKE = 5'd19;
  localparam logic [4:0] OP_GY_MUL = 5'd20;
  localparam logic [4:0] OP_GY_START = 5'd21;
  localparam logic [4:0] OP_GY_TAKE = 5'd22;
  localparam logic [4:0] OP_GZ_START = 5'd23;
  localparam logic [4:0] OP_GZ_TAKE = 5'd24;
  localparam logic [4:0] OP_INSIDE = 5'd25;
  localparam logic [4:0] OP_UPDATE = 5'd26;
  localparam logic [4:0] OP_FINAL = 5'd27;
  localparam logic [4:0] OP_EMPTY = 5'd28;

  typedef struct packed {
    logic [4:0]       op;
    logic [IDX_W-1:0] idx;
    logic             first;
  } psdq_cmd_t;

  typedef struct packed {
    logic func;
    logic in_map;
    logic s_zero;
    logic rout;
    logic oz_pos;
    logic sq_done;
    logic div_done;
    logic out_free;
  } psdq_sts_t;

  typedef struct packed {
    logic [CNT_W-1:0]   pillar_count;
    logic signed [16:0] map_min_x;
    logic signed [16:0] map_min_y;
    logic signed [16:0] map_min_z;
    logic signed [16:0] map_max_x;
    logic signed [16:0] map_max_y;
    logic signed [16:0] map_max_z;
  } psdq_cfg_t;

  typedef struct packed {
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic [15:0]        r;
    logic signed [16:0] zlo;
    logic signed [16:0] zhi;
  } psdq_entry_t;

endpackage

`default_nettype wire

### sv/psdq_sqrt.sv
// Iterative square root, two radicand bits per cycle, rounded to nearest.
// Uses psdq_pkg widths. Result holds after done until the next start.
`default_nettype none

module psdq_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [psdq_pkg::SQ_IN_W-1:0]  radicand,
  output logic                               done,
  output logic [psdq_pkg::SQ_STEPS:0]        root_out
);

  localparam int RW = psdq_pkg::SQ_STEPS;

  logic              busy;
  logic [4:0]        cnt;
  logic [psdq_pkg::SQ_IN_W-1:0] xs;
  logic [RW+1:0]     rem;
  logic [RW-1:0]     root;
  logic [RW+3:0]     rem_sh;
  logic [RW+3:0]     trial;
  logic [RW+1:0]     rem_next;
  logic [RW-1:0]     root_next;

  always_comb begin
    rem_sh = {rem, xs[psdq_pkg::SQ_IN_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    if (rem_sh >= trial) begin
      rem_next = (RW+2)'(rem_sh - trial);
      root_next = {root[RW-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[RW+1:0];
      root_next = {root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'(RW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs <= radicand;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      xs <= {xs[psdq_pkg::SQ_IN_W-3:0], 2'b00};
      rem <= rem_next;
      root <= root_next;
    end
  end

  // round up when the remainder exceeds the floor root
  assign root_out = {1'b0, root} + ((RW+1)'(rem > {2'b00, root}));

endmodule

`default_nettype wire

### sv/psdq_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses psdq_pkg widths. Quotient holds after done until the next start.
`default_nettype none

module psdq_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [psdq_pkg::DIV_NW-1:0]  num,
  input  wire logic [psdq_pkg::DIV_DW-1:0]  den,
  output logic                              done,
  output logic [psdq_pkg::DIV_NW-1:0]       quo
);

  localparam int NW = psdq_pkg::DIV_NW;
  localparam int DW = psdq_pkg::DIV_DW;

  logic          busy;
  logic [5:0]    cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_sh;
  logic [DW-1:0] rem_next;
  logic          qbit;

  always_comb begin
    rem_sh = {rem, quo[NW-1]};
    qbit = (rem_sh >= {1'b0, den_q});
    rem_next = qbit ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'(NW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      den_q <= den;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[NW-2:0], qbit};
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

### sv/psdq_dp.sv
// Datapath: pillar table, per-pillar arithmetic registers, shared root and
// divider, best-distance tracking and the result register.
// Depends on psdq_pkg, psdq_sqrt and psdq_div; driven by psdq_ctrl ops.
`default_nettype none

module psdq_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire psdq_pkg::psdq_cmd_t         cmd,
  input  wire psdq_pkg::psdq_cfg_t         cfg,
  input  wire logic [psdq_pkg::IN_W-1:0]   in_data,
  input  wire logic                        in_func,
  input  wire logic                        out_ready,
  output psdq_pkg::psdq_sts_t              sts,
  output logic                             out_valid,
  output logic [psdq_pkg::OUT_W-1:0]       out_data,
  output logic                             out_observed
);

  psdq_pkg::psdq_entry_t mem [psdq_pkg::MAX_PILLARS];
  psdq_pkg::psdq_entry_t ent;
  psdq_pkg::psdq_entry_t ld;
  psdq_pkg::psdq_entry_t ld_q;

  logic                       func_q;
  logic [psdq_pkg::IDX_W-1:0] slot_q;
  logic signed [16:0]         px, py, pz;

  logic signed [17:0] dx, dy, dzl, dzh;
  logic [34:0]        dx2, dy2;
  logic [31:0]        r2;
  logic [35:0]        s;
  logic [16:0]        oz;
  logic               rout;
  logic [26:0]        rq;
  logic signed [15:0] ux, uy;
  logic [26:0]        ex;
  logic [24:0]        ez;
  logic signed [27:0] mrad;
  logic signed [25:0] ib, it;
  logic [53:0]        ex2;
  logic [49:0]        ez2;
  logic [27:0]        dq;
  logic [41:0]        prod;
  logic signed [29:0] d;
  logic signed [15:0] gx, gy, gz;
  logic signed [29:0] best;
  logic signed [15:0] bgx, bgy, bgz;

  logic                               sq_start, sq_done;
  logic [psdq_pkg::SQ_IN_W-1:0]       sq_in;
  logic [psdq_pkg::SQ_STEPS:0]        sq_root;
  logic                               div_start, div_done;
  logic [psdq_pkg::DIV_NW-1:0]        div_num, div_q;
  logic [psdq_pkg::DIV_DW-1:0]        div_den;

  logic [17:0]        adx, ady;
  logic [15:0]        aux, auy;
  logic [15:0]        q16;
  logic signed [18:0] nzl, nzh, zmax;
  logic signed [27:0] exd;
  logic signed [27:0] ib28, it28, m;
  logic signed [15:0] mgx, mgy, mgz;
  logic [29:0]        bmag, bsum;
  logic [21:0]        dmag;
  logic [18:0]        dist_sat;
  logic               in_map;

  assign ld = '{cx: in_data[20:4], cy: in_data[37:21], r: in_data[53:38],
                zlo: in_data[70:54], zhi: in_data[87:71]};

  psdq_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root_out(sq_root)
  );

  psdq_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    adx = dx[17] ? 18'(-dx) : 18'(dx);
    ady = dy[17] ? 18'(-dy) : 18'(dy);
    aux = ux[15] ? 16'(-ux) : 16'(ux);
    auy = uy[15] ? 16'(-uy) : 16'(uy);
    q16 = div_q[15:0];
    nzl = -19'(dzl);
    nzh = -19'(dzh);
    zmax = (nzl > nzh) ? nzl : nzh;
    exd = $signed({1'b0, rq}) - $signed({4'b0, ent.r, 8'b0});
    ib28 = 28'(ib);
    it28 = 28'(it);

    sq_start = (cmd.op == psdq_pkg::OP_RQ_START) || (cmd.op == psdq_pkg::OP_DQ_START);
    sq_in = (cmd.op == psdq_pkg::OP_RQ_START) ? {2'b00, s, 16'b0} : ex2 + {4'b0, ez2};

    div_start = (cmd.op == psdq_pkg::OP_UX_START) || (cmd.op == psdq_pkg::OP_UY_START)
             || (cmd.op == psdq_pkg::OP_GX_START) || (cmd.op == psdq_pkg::OP_GY_START)
             || (cmd.op == psdq_pkg::OP_GZ_START);
    case (cmd.op)
      psdq_pkg::OP_UX_START: div_num = {2'b0, adx, 22'b0} + {16'b0, rq[26:1]};
      psdq_pkg::OP_UY_START: div_num = {2'b0, ady, 22'b0} + {16'b0, rq[26:1]};
      psdq_pkg::OP_GZ_START: div_num = {3'b0, ez, 14'b0} + {15'b0, dq[27:1]};
      default:               div_num = prod + {15'b0, dq[27:1]};
    endcase
    div_den = ((cmd.op == psdq_pkg::OP_UX_START) || (cmd.op == psdq_pkg::OP_UY_START))
            ? {1'b0, rq} : dq;

    // inside: radial, then bottom, then top, strict compare keeps the earlier
    m = mrad;
    mgx = ux;
    mgy = uy;
    mgz = '0;
    if (ib28 < m) begin
      m = ib28;
      mgx = '0;
      mgy = '0;
      mgz = -16'sd16384;
    end
    if (it28 < m) begin
      m = it28;
      mgx = '0;
      mgy = '0;
      mgz = 16'sd16384;
    end

    bmag = best[29] ? 30'(-best) : 30'(best);
    bsum = bmag + 30'd128;
    dmag = bsum[29:8];
    if (best[29]) begin
      dist_sat = (dmag > 22'd262144) ? 19'h40000 : 19'(-dmag);
    end else begin
      dist_sat = (dmag > 22'd262143) ? 19'h3FFFF : 19'(dmag);
    end

    in_map = (px >= cfg.map_min_x) && (px <= cfg.map_max_x)
          && (py >= cfg.map_min_y) && (py <= cfg.map_max_y)
          && (pz >= cfg.map_min_z) && (pz <= cfg.map_max_z);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == psdq_pkg::OP_LOAD) begin
      mem[slot_q] <= ld_q;
    end
    if (cmd.op == psdq_pkg::OP_READ) begin
      ent <= mem[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      psdq_pkg::OP_CAPTURE: begin
        func_q <= in_func;
        slot_q <= in_data[3:0];
        px <= in_data[104:88];
        py <= in_data[121:105];
        pz <= in_data[138:122];
        ld_q <= ld;
      end
      psdq_pkg::OP_DIFF: begin
        dx <= 18'(px) - 18'(ent.cx);
        dy <= 18'(py) - 18'(ent.cy);
        dzl <= 18'(pz) - 18'(ent.zlo);
        dzh <= 18'(ent.zhi) - 18'(pz);
      end
      psdq_pkg::OP_SQR: begin
        dx2 <= 35'(dx * dx);
        dy2 <= 35'(dy * dy);
        r2 <= ent.r * ent.r;
      end
      psdq_pkg::OP_SUM: begin
        s <= {1'b0, dx2} + {1'b0, dy2};
        oz <= (zmax > 19'sd0) ? zmax[16:0] : 17'd0;
        ux <= 16'sd16384;
        uy <= 16'sd0;
      end
      psdq_pkg::OP_RQ_START: rout <= (s > {4'b0, r2});
      psdq_pkg::OP_RQ_TAKE:  rq <= sq_root[26:0];
      psdq_pkg::OP_UX_TAKE:  ux <= dx[17] ? -q16 : q16;
      psdq_pkg::OP_UY_TAKE:  uy <= dy[17] ? -q16 : q16;
      psdq_pkg::OP_EXCESS: begin
        ex <= !rout ? 27'd0 : ((exd < 28'sd1) ? 27'd1 : exd[26:0]);
        ez <= {oz, 8'b0};
        mrad <= $signed({4'b0, ent.r, 8'b0}) - $signed({1'b0, rq});
        ib <= {dzl, 8'b0};
        it <= {dzh, 8'b0};
      end
      psdq_pkg::OP_EXSQ: begin
        ex2 <= ex * ex;
        ez2 <= ez * ez;
      end
      psdq_pkg::OP_DQ_TAKE: begin
        dq <= sq_root;
        d <= {2'b00, sq_root};
        gx <= '0;
        gy <= '0;
        gz <= '0;
      end
      psdq_pkg::OP_GX_MUL:  prod <= 42'(ex * aux);
      psdq_pkg::OP_GY_MUL:  prod <= 42'(ex * auy);
      psdq_pkg::OP_GX_TAKE: gx <= ux[15] ? -q16 : q16;
      psdq_pkg::OP_GY_TAKE: gy <= uy[15] ? -q16 : q16;
      // positive only when the point is above the top
      psdq_pkg::OP_GZ_TAKE: gz <= dzh[17] ? q16 : -q16;
      psdq_pkg::OP_INSIDE: begin
        d <= -30'(m);
        gx <= mgx;
        gy <= mgy;
        gz <= mgz;
      end
      psdq_pkg::OP_UPDATE: begin
        if (cmd.first || (d < best)) begin
          best <= d;
          bgx <= gx;
          bgy <= gy;
          bgz <= gz;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.op == psdq_pkg::OP_FINAL) || (cmd.op == psdq_pkg::OP_EMPTY)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == psdq_pkg::OP_FINAL) begin
      out_observed <= 1'b1;
      out_data <= {5'b0, bgz, bgy, bgx, dist_sat};
    end else if (cmd.op == psdq_pkg::OP_EMPTY) begin
      out_observed <= 1'b0;
      out_data <= '0;
    end
  end

  always_comb begin
    sts.func = func_q;
    sts.in_map = in_map;
    sts.s_zero = (s == '0);
    sts.rout = rout;
    sts.oz_pos = (oz != '0);
    sts.sq_done = sq_done;
    sts.div_done = div_done;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

### sv/psdq_ctrl.sv
// Sequencer: walks each query over the pillars in use and issues one
// datapath op per cycle outside its wait states. Depends on psdq_pkg; drives psdq_dp.
`default_nettype none

module psdq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [psdq_pkg::CNT_W-1:0]    pillar_count,
  input  wire psdq_pkg::psdq_sts_t           sts,
  output logic                               in_ready,
  output psdq_pkg::psdq_cmd_t                cmd
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DECIDE = 5'd1;
  localparam logic [4:0] ST_READ = 5'd2;
  localparam logic [4:0] ST_DIFF = 5'd3;
  localparam logic [4:0] ST_SQR = 5'd4;
  localparam logic [4:0] ST_SUM = 5'd5;
  localparam logic [4:0] ST_RQ_GO = 5'd6;
  localparam logic [4:0] ST_RQ_WAIT = 5'd7;
  localparam logic [4:0] ST_UX_GO = 5'd8;
  localparam logic [4:0] ST_UX_WAIT = 5'd9;
  localparam logic [4:0] ST_UY_GO = 5'd10;
  localparam logic [4:0] ST_UY_WAIT = 5'd11;
  localparam logic [4:0] ST_EXCESS = 5'd12;
  localparam logic [4:0] ST_EXSQ = 5'd13;
  localparam logic [4:0] ST_DQ_GO = 5'd14;
  localparam logic [4:0] ST_DQ_WAIT = 5'd15;
  localparam logic [4:0] ST_GX_MUL = 5'd16;
  localparam logic [4:0] ST_GX_GO = 5'd17;
  localparam logic [4:0] ST_GX_WAIT = 5'd18;
  localparam logic [4:0] ST_GY_MUL = 5'd19;
  localparam logic [4:0] ST_GY_GO = 5'd20;
  localparam logic [4:0] ST_GY_WAIT = 5'd21;
  localparam logic [4:0] ST_GZ_GO = 5'd22;
  localparam logic [4:0] ST_GZ_WAIT = 5'd23;
  localparam logic [4:0] ST_INSIDE = 5'd24;
  localparam logic [4:0] ST_UPDATE = 5'd25;
  localparam logic [4:0] ST_FINISH = 5'd26;

  logic [4:0]                 state, state_next;
  logic [psdq_pkg::IDX_W-1:0] idx, idx_next;
  logic                       empty, empty_next;
  logic [psdq_pkg::CNT_W-1:0] n_sat;
  logic [psdq_pkg::IDX_W-1:0] last_idx;

  assign n_sat = (pillar_count > psdq_pkg::CNT_W'(psdq_pkg::MAX_PILLARS))
               ? psdq_pkg::CNT_W'(psdq_pkg::MAX_PILLARS) : pillar_count;
  assign last_idx = psdq_pkg::IDX_W'(n_sat - psdq_pkg::CNT_W'(1));
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next = idx;
    empty_next = empty;
    cmd.op = psdq_pkg::OP_NONE;
    cmd.idx = idx;
    cmd.first = (idx == '0);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = psdq_pkg::OP_CAPTURE;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.func == psdq_pkg::FUNC_LOAD) begin
          cmd.op = psdq_pkg::OP_LOAD;
          state_next = ST_IDLE;
        end else if (!sts.in_map || (n_sat == '0)) begin
          empty_next = 1'b1;
          state_next = ST_FINISH;
        end else begin
          empty_next = 1'b0;
          idx_next = '0;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.op = psdq_pkg::OP_READ;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.op = psdq_pkg::OP_DIFF;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.op = psdq_pkg::OP_SQR;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op = psdq_pkg::OP_SUM;
        state_next = ST_RQ_GO;
      end
      ST_RQ_GO: begin
        cmd.op = psdq_pkg::OP_RQ_START;
        state_next = ST_RQ_WAIT;
      end
      ST_RQ_WAIT: begin
        if (sts.sq_done) begin
          cmd.op = psdq_pkg::OP_RQ_TAKE;
          state_next = sts.s_zero ? ST_EXCESS : ST_UX_GO;
        end
      end
      ST_UX_GO: begin
        cmd.op = psdq_pkg::OP_UX_START;
        state_next = ST_UX_WAIT;
      end
      ST_UX_WAIT: begin
        if (sts.div_done) begin
          cmd.op = psdq_pkg::OP_UX_TAKE;
          state_next = ST_UY_GO;
        end
      end
      ST_UY_GO: begin
        cmd.op = psdq_pkg::OP_UY_START;
        state_next = ST_UY_WAIT;
      end
      ST_UY_WAIT: begin
        if (sts.div_done) begin
          cmd.op = psdq_pkg::OP_UY_TAKE;
          state_next = ST_EXCESS;
        end
      end
      ST_EXCESS: begin
        cmd.op = psdq_pkg::OP_EXCESS;
        state_next = (sts.rout || sts.oz_pos) ? ST_EXSQ : ST_INSIDE;
      end
      ST_EXSQ: begin
        cmd.op = psdq_pkg::OP_EXSQ;
        state_next = ST_DQ_GO;
      end
      ST_DQ_GO: begin
        cmd.op = psdq_pkg::OP_DQ_START;
        state_next = ST_DQ_WAIT;
      end
      ST_DQ_WAIT: begin
        if (sts.sq_done) begin
          cmd.op = psdq_pkg::OP_DQ_TAKE;
          state_next = sts.rout ? ST_GX_MUL : ST_GZ_GO;
        end
      end
      ST_GX_MUL: begin
        cmd.op = psdq_pkg::OP_GX_MUL;
        state_next = ST_GX_GO;
      end
      ST_GX_GO: begin
        cmd.op = psdq_pkg::OP_GX_START;
        state_next = ST_GX_WAIT;
      end
      ST_GX_WAIT: begin
        if (sts.div_done) begin
          cmd.op = psdq_pkg::OP_GX_TAKE;
          state_next = ST_GY_MUL;
        end
      end
      ST_GY_MUL: begin
        cmd.op = psdq_pkg::OP_GY_MUL;
        state_next = ST_GY_GO;
      end
      ST_GY_GO: begin
        cmd.op = psdq_pkg::OP_GY_START;
        state_next = ST_GY_WAIT;
      end
      ST_GY_WAIT: begin
        if (sts.div_done) begin
          cmd.op = psdq_pkg::OP_GY_TAKE;
          state_next = sts.oz_pos ? ST_GZ_GO : ST_UPDATE;
        end
      end
      ST_GZ_GO: begin
        cmd.op = psdq_pkg::OP_GZ_START;
        state_next = ST_GZ_WAIT;
      end
      ST_GZ_WAIT: begin
        if (sts.div_done) begin
          cmd.op = psdq_pkg::OP_GZ_TAKE;
          state_next = ST_UPDATE;
        end
      end
      ST_INSIDE: begin
        cmd.op = psdq_pkg::OP_INSIDE;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.op = psdq_pkg::OP_UPDATE;
        if (idx == last_idx) begin
          state_next = ST_FINISH;
        end else begin
          idx_next = idx + psdq_pkg::IDX_W'(1);
          state_next = ST_READ;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.op = empty ? psdq_pkg::OP_EMPTY : psdq_pkg::OP_FINAL;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      empty <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      empty <= empty_next;
    end
  end

endmodule

`default_nettype wire

### sv/pillar_signed_distance_query.sv
// Top level: configuration registers on the APB port, sequencer and datapath.
// Depends on psdq_pkg, psdq_ctrl and psdq_dp.
//
//   channel   dir  handshake                 contents
//   s_*       in   s_tvalid/s_tready         load or query item
//   m_*       out  m_tvalid/m_tready         one result per query item
//   APB       in   psel/penable/pwrite       pillar count and map box
//
// A load item is captured, then written to its slot. A query is captured,
// checked against the map box and, per pillar in use, run through setup,
// arithmetic, up to two passes of the shared root and up to five of the
// shared divider. Out-of-map or empty-table queries skip the pillars and
// return an unobserved all-zero result. Reset is synchronous and restores
// control and config state; the table holds nothing until loaded. A
// stalled result holds the next query in its last step until m_tready.
`default_nettype none

module pillar_signed_distance_query (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // slot, center_x, center_y, radius, z_low, z_high, point_x, point_y, point_z
  input  wire logic [143:0] s_tdata,
  // func
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // distance, grad_x, grad_y, grad_z
  output logic [71:0]       m_tdata,
  // observed
  output logic              m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  psdq_pkg::psdq_cfg_t cfg;
  psdq_pkg::psdq_cmd_t cmd;
  psdq_pkg::psdq_sts_t sts;
  logic                wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pillar_count <= '0;
      cfg.map_min_x <= -17'sd65536;
      cfg.map_min_y <= -17'sd65536;
      cfg.map_min_z <= -17'sd65536;
      cfg.map_max_x <= 17'sd65535;
      cfg.map_max_y <= 17'sd65535;
      cfg.map_max_z <= 17'sd65535;
    end else if (wr) begin
      unique case (paddr[4:2])
        psdq_pkg::REG_PILLAR_COUNT: cfg.pillar_count <= pwdata[4:0];
        psdq_pkg::REG_MAP_MIN_X:    cfg.map_min_x <= pwdata[16:0];
        psdq_pkg::REG_MAP_MIN_Y:    cfg.map_min_y <= pwdata[16:0];
        psdq_pkg::REG_MAP_MIN_Z:    cfg.map_min_z <= pwdata[16:0];
        psdq_pkg::REG_MAP_MAX_X:    cfg.map_max_x <= pwdata[16:0];
        psdq_pkg::REG_MAP_MAX_Y:    cfg.map_max_y <= pwdata[16:0];
        psdq_pkg::REG_MAP_MAX_Z:    cfg.map_max_z <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      psdq_pkg::REG_PILLAR_COUNT: prdata = {27'b0, cfg.pillar_count};
      psdq_pkg::REG_MAP_MIN_X:    prdata = 32'(cfg.map_min_x);
      psdq_pkg::REG_MAP_MIN_Y:    prdata = 32'(cfg.map_min_y);
      psdq_pkg::REG_MAP_MIN_Z:    prdata = 32'(cfg.map_min_z);
      psdq_pkg::REG_MAP_MAX_X:    prdata = 32'(cfg.map_max_x);
      psdq_pkg::REG_MAP_MAX_Y:    prdata = 32'(cfg.map_max_y);
      psdq_pkg::REG_MAP_MAX_Z:    prdata = 32'(cfg.map_max_z);
      default:                    prdata = '0;
    endcase
  end

  psdq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .pillar_count(cfg.pillar_count),
    .sts(sts), .in_ready(s_tready), .cmd(cmd)
  );

  psdq_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .in_data(s_tdata),
    .in_func(s_tuser), .out_ready(m_tready), .sts(sts), .out_valid(m_tvalid),
    .out_data(m_tdata), .out_observed(m_tuser)
  );

endmodule

`default_nettype wire

### sv/psdq_checker.sv
// Port-level checks for pillar_signed_distance_query, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module psdq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic        m_tuser
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // unobserved result carries all zeros
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 72'd0)
    else $error("unobserved result not zero");

  // x and z gradient components stay within unit magnitude
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[34:19]) <= 16'sd16384)
              && ($signed(m_tdata[34:19]) >= -16'sd16384)
              && ($signed(m_tdata[66:51]) <= 16'sd16384)
              && ($signed(m_tdata[66:51]) >= -16'sd16384))
    else $error("gradient out of range");

  // no result straight out of reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind pillar_signed_distance_query psdq_checker u_psdq_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

`default_nettype wire
